### rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants and types of the stream pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int PAT_MIN     = 5;
	localparam int CFG_BYTES   = 16;
	localparam int QDEPTH      = 16;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W  = $clog2(MAX_PATTERN);
	localparam int LEN_W  = 5;
	localparam int CNT_W  = 24;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [7:0]       BYTE_ZERO = 8'h00;
	localparam logic [7:0]       BYTE_ONES = 8'hFF;

	typedef enum logic [2:0] {
		CFG_PAT_LO  = 3'd0,
		CFG_PAT_HI  = 3'd1,
		CFG_REP_LO  = 3'd2,
		CFG_REP_HI  = 3'd3,
		CFG_PAT_LEN = 3'd4,
		CFG_REP_LEN = 3'd5,
		CFG_DRY_RUN = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data;
		logic       step_end;
	} q_byte_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             last;
		logic             invalid;
	} q_rec_t;

	typedef struct packed {
		logic    byte_vld;
		q_byte_t byte_ent;
		logic    rec_vld;
		q_rec_t  rec_ent;
	} q_push_t;

	typedef struct packed {
		logic    ok;
		q_byte_t byte_ent;
		q_rec_t  rec_ent;
	} q_head_t;

endpackage

### rtl/core/stream_pattern_replace.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Byte stream find and replace with non-overlapping matches.
//
// Input beats (data_byte, final_byte) enter on in_valid/in_ready; output
// beats (out_byte, out_last, match_total, setup_invalid) leave on
// out_valid/out_ready. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. A byte leaves once the window of pattern_length
// bytes behind it is full, via the queue and output register; with an
// invalid setup each byte is queued as it enters. Throughput is one beat per
// cycle while the front is not flushing and the queue has room, set by the
// single window check and shift done per cycle in the front. A final beat
// flushes the window at one beat per cycle while the queue has room and
// holds the input meanwhile, as does a mid-stream pattern length shrink.
// A 16-entry queue parts front and back, so a stalled sink fills the queue
// before in_ready drops. Reset clears window, counters, queue and output,
// and loads the register defaults (pattern length 5, replace length 1).
// ----------------------------------------------------------------------------
module stream_pattern_replace (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [63:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      final_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      out_last,
	output logic [spr_pkg::CNT_W-1:0] match_total,
	output logic                      setup_invalid
);
	import spr_pkg::*;

	q_push_t push;
	q_head_t head;
	logic    room;
	logic    pop;

	spr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_room     (room),
		.push       (push)
	);

	spr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.pop    (pop),
		.head   (head)
	);

	spr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.match_total   (match_total),
		.setup_invalid (setup_invalid)
	);

endmodule

### rtl/core/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front
// Configuration registers, sliding window, match check, rewrite and flush.
// ----------------------------------------------------------------------------
module spr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  final_byte,
	input  logic                  q_room,
	output spr_pkg::q_push_t      push
);
	import spr_pkg::*;

	logic [63:0]       pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
	logic [LEN_W-1:0]  plen_q, rlen_q;
	logic              dry_q;

	logic [7:0]        win_q [MAX_PATTERN];
	logic [FILL_W-1:0] fill_q;
	logic [LEN_W-1:0]  blk_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              last_q;

	logic [7:0]        pat [MAX_PATTERN];
	logic [7:0]        rep [MAX_PATTERN];
	logic [7:0]        win_a [MAX_PATTERN];
	logic [7:0]        win_c [MAX_PATTERN];
	logic [7:0]        win_p [MAX_PATTERN];
	logic [FILL_W-1:0] fill_a, f, f_p;
	logic [LEN_W-1:0]  len, blk_n;
	logic [CNT_W-1:0]  cnt_n;
	logic              setup_ok, same, all_eq, last_c;
	logic              in_fire, go, do_iter, do_pop, more;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < 8) begin
				pat[i] = pat_lo_q[8*i +: 8];
				rep[i] = rep_lo_q[8*i +: 8];
			end else if (i < CFG_BYTES) begin
				pat[i] = pat_hi_q[8*(i-8) +: 8];
				rep[i] = rep_hi_q[8*(i-8) +: 8];
			end else begin
				pat[i] = BYTE_ZERO;
				rep[i] = BYTE_ZERO;
			end
		end
	end

	always_comb begin
		same = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < plen_q && pat[i] != rep[i])
				same = 1'b0;
		end
		setup_ok = (plen_q >= LEN_W'(PAT_MIN)) && (plen_q <= LEN_W'(MAX_PATTERN))
			&& (rlen_q != '0) && (rlen_q <= plen_q)
			&& (pat[0] != BYTE_ZERO) && (pat[0] != BYTE_ONES)
			&& !((rlen_q == plen_q) && same);
		len = setup_ok ? plen_q : LEN_W'(1);
	end

	assign in_ready = !busy_q && q_room;
	assign in_fire  = in_valid && in_ready;
	assign go       = in_fire || (busy_q && q_room);

	always_comb begin
		fill_a = (fill_q >= FILL_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN - 1) : fill_q;
		for (int i = 0; i < MAX_PATTERN; i++)
			win_a[i] = win_q[i];
		if (!busy_q)
			win_a[fill_a[IDX_W-1:0]] = data_byte;
		f      = busy_q ? fill_q : fill_a + FILL_W'(1);
		last_c = busy_q ? last_q : final_byte;

		do_iter = (LEN_W'(f) >= len);
		do_pop  = do_iter || (last_c && f != '0);

		all_eq = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LEN_W'(i) < len && win_a[i] != pat[i])
				all_eq = 1'b0;
		end

		blk_n = blk_q;
		cnt_n = cnt_q;
		for (int i = 0; i < MAX_PATTERN; i++)
			win_c[i] = win_a[i];
		if (do_iter) begin
			if (blk_q != '0) begin
				blk_n = blk_q - LEN_W'(1);
			end else if (setup_ok && all_eq) begin
				if (cnt_q != COUNT_MAX)
					cnt_n = cnt_q + CNT_W'(1);
				blk_n = len - LEN_W'(1);
				if (!dry_q) begin
					for (int i = 0; i < MAX_PATTERN; i++) begin
						if (LEN_W'(i) < len)
							win_c[i] = (LEN_W'(i) < rlen_q) ? rep[i] : BYTE_ZERO;
					end
				end
			end
		end

		for (int i = 0; i < MAX_PATTERN; i++)
			win_p[i] = (i < MAX_PATTERN - 1) ? win_c[(i + 1) % MAX_PATTERN] : BYTE_ZERO;
		f_p  = f - FILL_W'(1);
		more = (LEN_W'(f_p) >= len) || (last_c && f_p != '0);

		push.byte_vld          = go && do_pop;
		push.byte_ent.data     = win_c[0];
		push.byte_ent.step_end = !more;
		push.rec_vld           = go && do_pop && !more;
		push.rec_ent.count     = cnt_n;
		push.rec_ent.last      = last_c;
		push.rec_ent.invalid   = !setup_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			rep_lo_q <= '0;
			rep_hi_q <= '0;
			plen_q   <= LEN_W'(5);
			rlen_q   <= LEN_W'(1);
			dry_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PAT_LO:  pat_lo_q <= cfg_data;
				CFG_PAT_HI:  pat_hi_q <= cfg_data;
				CFG_REP_LO:  rep_lo_q <= cfg_data;
				CFG_REP_HI:  rep_hi_q <= cfg_data;
				CFG_PAT_LEN: plen_q   <= cfg_data[LEN_W-1:0];
				CFG_REP_LEN: rlen_q   <= cfg_data[LEN_W-1:0];
				CFG_DRY_RUN: dry_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN; i++)
				win_q[i] <= BYTE_ZERO;
			fill_q <= '0;
			blk_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			last_q <= 1'b0;
		end else if (go) begin
			last_q <= last_c;
			if (do_pop) begin
				busy_q <= more;
				if (!more && last_c) begin
					for (int i = 0; i < MAX_PATTERN; i++)
						win_q[i] <= BYTE_ZERO;
					fill_q <= '0;
					blk_q  <= '0;
					cnt_q  <= '0;
				end else begin
					for (int i = 0; i < MAX_PATTERN; i++)
						win_q[i] <= win_p[i];
					fill_q <= f_p;
					blk_q  <= blk_n;
					cnt_q  <= cnt_n;
				end
			end else begin
				busy_q <= 1'b0;
				for (int i = 0; i < MAX_PATTERN; i++)
					win_q[i] <= win_a[i];
				fill_q <= f;
			end
		end
	end

endmodule

### rtl/core/spr_queue.sv
// ----------------------------------------------------------------------------
// spr_queue
// Byte queue and per-step record queue between front and back.
// ----------------------------------------------------------------------------
module spr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  spr_pkg::q_push_t push,
	output logic             room,
	input  logic             pop,
	output spr_pkg::q_head_t head
);
	import spr_pkg::*;

	q_byte_t           byte_mem [QDEPTH];
	q_rec_t            rec_mem  [QDEPTH];
	logic [QPTR_W-1:0] bwr_q, brd_q, rwr_q, rrd_q;
	logic [QCNT_W-1:0] bcnt_q, rcnt_q;
	logic              pop_rec;

	assign room          = (bcnt_q != QCNT_W'(QDEPTH));
	assign head.ok       = (bcnt_q != '0) && (rcnt_q != '0);
	assign head.byte_ent = byte_mem[brd_q];
	assign head.rec_ent  = rec_mem[rrd_q];
	assign pop_rec       = pop && head.byte_ent.step_end;

	always_ff @(posedge clk) begin
		if (push.byte_vld)
			byte_mem[bwr_q] <= push.byte_ent;
		if (push.rec_vld)
			rec_mem[rwr_q] <= push.rec_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bwr_q  <= '0;
			brd_q  <= '0;
			rwr_q  <= '0;
			rrd_q  <= '0;
			bcnt_q <= '0;
			rcnt_q <= '0;
		end else begin
			if (push.byte_vld)
				bwr_q <= bwr_q + QPTR_W'(1);
			if (pop)
				brd_q <= brd_q + QPTR_W'(1);
			if (push.rec_vld)
				rwr_q <= rwr_q + QPTR_W'(1);
			if (pop_rec)
				rrd_q <= rrd_q + QPTR_W'(1);
			bcnt_q <= bcnt_q + QCNT_W'(push.byte_vld) - QCNT_W'(pop);
			rcnt_q <= rcnt_q + QCNT_W'(push.rec_vld) - QCNT_W'(pop_rec);
		end
	end

endmodule

### rtl/core/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back
// Output register: takes queue beats and holds them while the sink stalls.
// ----------------------------------------------------------------------------
module spr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spr_pkg::q_head_t          head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      out_last,
	output logic [spr_pkg::CNT_W-1:0] match_total,
	output logic                      setup_invalid
);
	import spr_pkg::*;

	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [CNT_W-1:0] total_q;
	logic             inval_q;

	assign pop           = head.ok && (!valid_q || out_ready);
	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign out_last      = last_q;
	assign match_total   = total_q;
	assign setup_invalid = inval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q  <= head.byte_ent.data;
			last_q  <= head.byte_ent.step_end && head.rec_ent.last;
			total_q <= head.rec_ent.count;
			inval_q <= head.rec_ent.invalid;
		end
	end

endmodule
